// ----- rtl/esi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge sphere interpolator package
// Item types, defaults and the controller to datapath command and status
// groups shared by the modules of the interpolator.
// ----------------------------------------------------------------------------
package esi_pkg;

    localparam int MAX_SPHERES_DEF = 64;
    localparam int FRAC_BITS_DEF   = 16;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic        [30:0] start_radius;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic        [30:0] end_radius;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sphere_x;
        logic signed [31:0] sphere_y;
        logic signed [31:0] sphere_z;
        logic        [30:0] sphere_radius;
        logic               last_of_edge;
        logic               count_capped;
    } out_item_t;

    // Which quotient the shared divider is working on.
    typedef enum logic [2:0] {
        DIV_UX,
        DIV_UY,
        DIV_UZ,
        DIV_CNT,
        DIV_H
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     square;
        logic     sqrt_go;
        logic     dist_take;
        logic     div_go;
        logic     div_take;
        div_sel_t div_sel;
        logic     emit_init;
        logic     step_h;
        logic     step_rad;
        logic     step_mul;
        logic     step_acc;
        logic     out_load;
    } esi_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
        logic skip_edge;
        logic count_low;
        logic last;
    } esi_sts_t;

endpackage

// ----- rtl/esi_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring division, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module esi_div #(
    parameter int WIDTH = 52
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dvs_reg;
    logic [WIDTH:0]   shifted;
    logic [WIDTH+1:0] diff;
    logic             ge;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[WIDTH-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        ge      = ~diff[WIDTH+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            quo_reg <= {quo_reg[WIDTH-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/esi_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative square root
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module esi_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [64:0] trial;
    logic        ge;

    always_comb
    begin
        trial = {1'b0, res_reg} + {1'b0, bit_reg};
        ge    = {1'b0, v_reg} >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg && bit_reg[0])
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                v_reg   <= v_reg - trial[63:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

// ----- rtl/esi_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge sphere interpolator datapath
// Edge geometry, the shared divider and square root, and the sphere stepper.
// ----------------------------------------------------------------------------
module esi_datapath #(
    parameter int FRAC_BITS   = esi_pkg::FRAC_BITS_DEF,
    parameter int MAX_SPHERES = esi_pkg::MAX_SPHERES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  esi_pkg::in_item_t in_item,
    input  esi_pkg::esi_cmd_t cmd,
    output esi_pkg::esi_sts_t sts,
    output esi_pkg::out_item_t out_item
);

    localparam int DIV_W  = 36 + FRAC_BITS;
    localparam int UMAG_W = FRAC_BITS + 3;
    localparam int CNT_W  = 35 + FRAC_BITS;
    localparam int N_W    = $clog2(MAX_SPHERES + 1);
    localparam int HACC_W = 33 + N_W;
    localparam int PROD_W = 31 + UMAG_W;
    localparam int STEP_W = PROD_W - FRAC_BITS;
    localparam int P_W    = STEP_W + N_W + 2;

    function automatic logic [31:0] sat32(input logic signed [P_W-1:0] v);
        logic [31:0] r;
        if ((v[P_W-1:31] == '0) || (v[P_W-1:31] == '1))
            r = v[31:0];
        else if (v[P_W-1])
            r = 32'h8000_0000;
        else
            r = 32'h7FFF_FFFF;
        return r;
    endfunction

    logic signed [31:0]       start_c [3];
    logic signed [31:0]       end_c [3];
    logic signed [32:0]       d_c [3];
    logic        [32:0]       dmag_reg [3];
    logic                     dneg_reg [3];
    logic signed [P_W-1:0]    p_reg [3];
    logic        [30:0]       r1_reg;
    logic        [30:0]       r2_reg;
    logic        [61:0]       sq_reg [3];
    logic        [30:0]       m_c [3];
    logic                     shift_c;
    logic        [32:0]       dist_reg;
    logic        [UMAG_W-1:0] umag_reg [3];
    logic        [CNT_W-1:0]  count_reg;
    logic        [31:0]       hmag_reg;
    logic        [N_W-1:0]    n_reg;
    logic                     capped_reg;
    logic        [N_W-1:0]    i_reg;
    logic signed [HACC_W-1:0] hacc_reg;
    logic        [30:0]       r_reg;
    logic        [PROD_W-1:0] prod_reg [3];
    esi_pkg::out_item_t       out_reg;

    logic        [31:0]       rsum_c;
    logic        [30:0]       big_c;
    logic        [30:0]       small_c;
    logic        [30:0]       rdiff_c;
    logic signed [35:0]       num_c;
    logic        [CNT_W-FRAC_BITS-1:0] n_full_c;
    logic                     hneg_c;
    logic signed [HACC_W-1:0] hstep_c;
    logic signed [HACC_W:0]   rad_c;
    logic        [63:0]       sqrt_in;
    logic        [31:0]       root;
    logic                     sqrt_done;
    logic        [DIV_W-1:0]  div_dividend;
    logic        [DIV_W-1:0]  div_divisor;
    logic        [DIV_W-1:0]  quotient;
    logic                     div_done;

    always_comb
    begin
        start_c[0] = in_item.start_x;
        start_c[1] = in_item.start_y;
        start_c[2] = in_item.start_z;
        end_c[0]   = in_item.end_x;
        end_c[1]   = in_item.end_y;
        end_c[2]   = in_item.end_z;
        for (int k = 0; k < 3; k++)
        begin
            d_c[k] = 33'(end_c[k]) - 33'(start_c[k]);
        end
        shift_c = |{dmag_reg[0][32:31], dmag_reg[1][32:31], dmag_reg[2][32:31]};
        for (int k = 0; k < 3; k++)
        begin
            m_c[k] = shift_c ? dmag_reg[k][31:1] : dmag_reg[k][30:0];
        end
        sqrt_in  = 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
        rsum_c   = {1'b0, r1_reg} + {1'b0, r2_reg};
        hneg_c   = r2_reg < r1_reg;
        big_c    = hneg_c ? r1_reg : r2_reg;
        small_c  = hneg_c ? r2_reg : r1_reg;
        rdiff_c  = big_c - small_c;
        num_c    = $signed({2'b00, dist_reg, 1'b0}) - $signed({5'b0, big_c})
                 + $signed({5'b0, small_c});
        n_full_c = count_reg[CNT_W-1:FRAC_BITS];
        hstep_c  = hneg_c ? -$signed(HACC_W'(hmag_reg)) : $signed(HACC_W'(hmag_reg));
        rad_c    = $signed({{(HACC_W-30){1'b0}}, r1_reg}) + (HACC_W+1)'(hacc_reg);
    end

    always_comb
    begin
        case (cmd.div_sel)
            esi_pkg::DIV_UX:
            begin
                div_dividend = DIV_W'(dmag_reg[0]) << FRAC_BITS;
                div_divisor  = DIV_W'(dist_reg);
            end
            esi_pkg::DIV_UY:
            begin
                div_dividend = DIV_W'(dmag_reg[1]) << FRAC_BITS;
                div_divisor  = DIV_W'(dist_reg);
            end
            esi_pkg::DIV_UZ:
            begin
                div_dividend = DIV_W'(dmag_reg[2]) << FRAC_BITS;
                div_divisor  = DIV_W'(dist_reg);
            end
            esi_pkg::DIV_CNT:
            begin
                div_dividend = DIV_W'(num_c[34:0]) << FRAC_BITS;
                div_divisor  = DIV_W'(rsum_c);
            end
            esi_pkg::DIV_H:
            begin
                div_dividend = DIV_W'(rdiff_c) << FRAC_BITS;
                div_divisor  = DIV_W'(count_reg);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = DIV_W'(dist_reg);
            end
        endcase
    end

    esi_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_go),
        .radicand (sqrt_in),
        .done     (sqrt_done),
        .root     (root)
    );

    esi_div #(
        .WIDTH (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dmag_reg[k] <= d_c[k][32] ? -d_c[k] : d_c[k];
                dneg_reg[k] <= d_c[k][32];
                p_reg[k]    <= P_W'(start_c[k]);
            end
            r1_reg <= in_item.start_radius;
            r2_reg <= in_item.end_radius;
        end
        if (cmd.square)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= 62'(m_c[k]) * 62'(m_c[k]);
            end
        end
        if (cmd.dist_take)
        begin
            dist_reg <= shift_c ? {root, 1'b0} : {1'b0, root};
        end
        if (cmd.div_take)
        begin
            case (cmd.div_sel)
                esi_pkg::DIV_UX:  umag_reg[0] <= quotient[UMAG_W-1:0];
                esi_pkg::DIV_UY:  umag_reg[1] <= quotient[UMAG_W-1:0];
                esi_pkg::DIV_UZ:  umag_reg[2] <= quotient[UMAG_W-1:0];
                esi_pkg::DIV_CNT: count_reg   <= quotient[CNT_W-1:0];
                esi_pkg::DIV_H:   hmag_reg    <= quotient[31:0];
                default:          hmag_reg    <= hmag_reg;
            endcase
        end
        if (cmd.emit_init)
        begin
            if (n_full_c > (CNT_W-FRAC_BITS)'(MAX_SPHERES))
            begin
                n_reg      <= N_W'(MAX_SPHERES);
                capped_reg <= 1'b1;
            end
            else
            begin
                n_reg      <= n_full_c[N_W-1:0];
                capped_reg <= 1'b0;
            end
            i_reg    <= '0;
            hacc_reg <= '0;
        end
        if (cmd.step_h)
        begin
            hacc_reg <= hacc_reg + hstep_c;
            i_reg    <= i_reg + 1'b1;
        end
        if (cmd.step_rad)
        begin
            if (rad_c[HACC_W])
                r_reg <= '0;
            else if (rad_c[HACC_W-1:31] != '0)
                r_reg <= 31'h7FFF_FFFF;
            else
                r_reg <= rad_c[30:0];
        end
        if (cmd.step_mul)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= PROD_W'(r_reg) * PROD_W'(umag_reg[k]);
            end
        end
        if (cmd.step_acc)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (dneg_reg[k])
                    p_reg[k] <= p_reg[k] - P_W'(prod_reg[k][PROD_W-1:FRAC_BITS]);
                else
                    p_reg[k] <= p_reg[k] + P_W'(prod_reg[k][PROD_W-1:FRAC_BITS]);
            end
        end
        if (cmd.out_load)
        begin
            out_reg.sphere_x      <= sat32(p_reg[0]);
            out_reg.sphere_y      <= sat32(p_reg[1]);
            out_reg.sphere_z      <= sat32(p_reg[2]);
            out_reg.sphere_radius <= r_reg;
            out_reg.last_of_edge  <= (i_reg == n_reg);
            out_reg.count_capped  <= capped_reg;
        end
    end

    always_comb
    begin
        sts.sqrt_done = sqrt_done;
        sts.div_done  = div_done;
        sts.skip_edge = (dist_reg == '0) || (rsum_c == '0) || num_c[35] || (num_c == '0);
        sts.count_low = (n_full_c == '0);
        sts.last      = (i_reg == n_reg);
    end

    assign out_item = out_reg;

endmodule

// ----- rtl/esi_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge sphere interpolator controller
// Sequences the edge setup, the divisions and the per-sphere steps.
// ----------------------------------------------------------------------------
module esi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output esi_pkg::esi_cmd_t cmd,
    input  esi_pkg::esi_sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_SQ_SUM,
        S_SQRT_WAIT,
        S_CHECK,
        S_DIV_GO,
        S_DIV_RUN,
        S_CNT_CHECK,
        S_EMIT_INIT,
        S_STEP_H,
        S_STEP_RAD,
        S_STEP_MUL,
        S_STEP_ACC,
        S_STEP_SAT,
        S_OUT
    } state_t;

    state_t            state_reg, state_next;
    esi_pkg::div_sel_t sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.div_sel = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_SQ_SUM;
            end
            S_SQ_SUM:
            begin
                cmd.sqrt_go = 1'b1;
                state_next  = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                cmd.dist_take = sts.sqrt_done;
                if (sts.sqrt_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.skip_edge)
                    state_next = S_IDLE;
                else
                begin
                    sel_next   = esi_pkg::DIV_UX;
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                cmd.div_go = 1'b1;
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                cmd.div_take = sts.div_done;
                if (sts.div_done)
                begin
                    case (sel_reg)
                        esi_pkg::DIV_UX:
                        begin
                            sel_next   = esi_pkg::DIV_UY;
                            state_next = S_DIV_GO;
                        end
                        esi_pkg::DIV_UY:
                        begin
                            sel_next   = esi_pkg::DIV_UZ;
                            state_next = S_DIV_GO;
                        end
                        esi_pkg::DIV_UZ:
                        begin
                            sel_next   = esi_pkg::DIV_CNT;
                            state_next = S_DIV_GO;
                        end
                        esi_pkg::DIV_CNT: state_next = S_CNT_CHECK;
                        default:          state_next = S_EMIT_INIT;
                    endcase
                end
            end
            S_CNT_CHECK:
            begin
                if (sts.count_low)
                    state_next = S_IDLE;
                else
                begin
                    sel_next   = esi_pkg::DIV_H;
                    state_next = S_DIV_GO;
                end
            end
            S_EMIT_INIT:
            begin
                cmd.emit_init = 1'b1;
                state_next    = S_STEP_H;
            end
            S_STEP_H:
            begin
                cmd.step_h = 1'b1;
                state_next = S_STEP_RAD;
            end
            S_STEP_RAD:
            begin
                cmd.step_rad = 1'b1;
                state_next   = S_STEP_MUL;
            end
            S_STEP_MUL:
            begin
                cmd.step_mul = 1'b1;
                state_next   = S_STEP_ACC;
            end
            S_STEP_ACC:
            begin
                cmd.step_acc = 1'b1;
                state_next   = S_STEP_SAT;
            end
            S_STEP_SAT:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = sts.last ? S_IDLE : S_STEP_H;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= esi_pkg::DIV_UX;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

endmodule

// ----- rtl/edge_sphere_interpolator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge sphere interpolator
// Turns one skeleton edge (two endpoint spheres) into a chain of in-between
// spheres along the edge, up to MAX_SPHERES of them.
// ----------------------------------------------------------------------------
// Setup: from accept until the first item is offered, the block runs the
//   square root and then five one-bit-per-cycle divisions on the single
//   shared divider before it steps the first sphere.
// Flow: one edge at a time; after setup each sphere steps through the states
//   S_STEP_H to S_STEP_SAT and then waits in S_OUT for any output stall.
// Reset: rst_n clears the controller and the arithmetic units asynchronously;
//   the block then waits idle for an input item.
// ----------------------------------------------------------------------------
module edge_sphere_interpolator_unit #(
    parameter int FRAC_BITS   = esi_pkg::FRAC_BITS_DEF,
    parameter int MAX_SPHERES = esi_pkg::MAX_SPHERES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  esi_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output esi_pkg::out_item_t out_item
);

    // The controller steps through edge setup (differences, squares, root,
    // direction, count and radius step divisions) and then loops once per
    // sphere, holding the input stalled until the edge's last sphere is taken.
    esi_pkg::esi_cmd_t cmd;
    esi_pkg::esi_sts_t sts;

    esi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds the edge, the direction and step values, the running
    // center, and the output register that keeps an item steady while the
    // downstream side stalls.
    esi_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .MAX_SPHERES (MAX_SPHERES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (out_item)
    );

endmodule

// ----- rtl/esi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge sphere interpolator checker
// Port-level assertions on the interpolator, attached by bind.
// ----------------------------------------------------------------------------
module esi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input esi_pkg::out_item_t out_item,
    input logic               out_valid,
    input logic               out_stall
);

    // A stalled item stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    // A stalled item does not change.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_item))
        else $error("output item changed while stalled");

    // One edge at a time: an accepted item closes the input.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after an accept");

    // No new edge while spheres of the current one are pending.
    a_no_accept_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while an item is pending");

    // Spheres of one edge are spaced by the step sequence.
    a_gap_between_items: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_item.last_of_edge |=> !out_valid)
        else $error("items of one edge delivered back to back");

endmodule

bind edge_sphere_interpolator_unit esi_checker u_esi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall)
);
